[hdl/rgb2hsv_pkg.sv]
package rgb2hsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 16;
    localparam int SAT_BITS     = 16;
    localparam int DIV_STEPS    = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;

    // stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_BITS = ((3 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((HUE_BITS + SAT_BITS + CHANNEL_BITS + 7) / 8) * 8;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    // item handed from classifier to divider back end
    typedef struct packed {
        logic                    black;
        logic                    gray;
        logic [2:0]              base;
        logic                    add;
        chan_t                   num;
        chan_t                   delta;
        chan_t                   maxv;
    } cls_t;

endpackage

[hdl/rgb2hsv_front.sv]
module rgb2hsv_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rgb2hsv_pkg::chan_t        red,
    input  rgb2hsv_pkg::chan_t        green,
    input  rgb2hsv_pkg::chan_t        blue,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rgb2hsv_pkg::cls_t         out_item
);

    rgb2hsv_pkg::cls_t  item_next;
    rgb2hsv_pkg::cls_t  item_reg;
    logic               valid_reg;
    rgb2hsv_pkg::chan_t mx;
    rgb2hsv_pkg::chan_t mn;

    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        item_next.maxv  = mx;
        item_next.delta = mx - mn;
        item_next.black = (mx == '0);
        item_next.gray  = (mx == mn);
        if (red == mx) begin
            if (green == mn) begin
                item_next.base = 3'd5; item_next.num = mx - blue;  item_next.add = 1'b1;
            end else begin
                item_next.base = 3'd1; item_next.num = mx - green; item_next.add = 1'b0;
            end
        end else if (green == mx) begin
            if (blue == mn) begin
                item_next.base = 3'd1; item_next.num = mx - red;   item_next.add = 1'b1;
            end else begin
                item_next.base = 3'd3; item_next.num = mx - blue;  item_next.add = 1'b0;
            end
        end else begin
            if (red == mn) begin
                item_next.base = 3'd3; item_next.num = mx - green; item_next.add = 1'b1;
            end else begin
                item_next.base = 3'd5; item_next.num = mx - red;   item_next.add = 1'b0;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

[hdl/rgb2hsv_fifo.sv]
module rgb2hsv_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rgb2hsv_pkg::cls_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output rgb2hsv_pkg::cls_t out_item
);

    rgb2hsv_pkg::cls_t                 mem [rgb2hsv_pkg::FIFO_DEPTH];
    logic [rgb2hsv_pkg::FIFO_AW-1:0]   wr_reg;
    logic [rgb2hsv_pkg::FIFO_AW-1:0]   rd_reg;
    logic [rgb2hsv_pkg::FIFO_AW:0]     cnt_reg;
    logic                              push;
    logic                              pop;

    assign in_ready  = (cnt_reg != 3'(rgb2hsv_pkg::FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_item;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(rgb2hsv_pkg::FIFO_DEPTH))
        else $error("fifo count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("fifo count push");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_reg == rd_reg))
        else $error("fifo pointers out of step");

endmodule

[hdl/rgb2hsv_back.sv]
module rgb2hsv_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rgb2hsv_pkg::cls_t           in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [15:0]                 hue,
    output logic [15:0]                 saturation,
    output rgb2hsv_pkg::chan_t          value
);

    localparam int NS = rgb2hsv_pkg::DIV_STEPS + 1;
    localparam int CB = rgb2hsv_pkg::CHANNEL_BITS;
    localparam int HW = CB + 3;   // width of 6*delta and of the hue term
    localparam int SW = CB;       // width of the saturation remainder

    // one restoring quotient bit per stage, both divisions side by side
    logic              v_reg    [NS];
    logic              blk_reg  [NS];
    logic              gry_reg  [NS];
    rgb2hsv_pkg::chan_t mx_reg  [NS];
    logic [HW-1:0]     hd_reg   [NS];
    logic [HW:0]       hr_reg   [NS];
    logic [15:0]       hq_reg   [NS];
    logic [SW:0]       sr_reg   [NS];
    logic [15:0]       sq_reg   [NS];
    logic              adv;

    logic [HW-1:0]     term0;
    logic [HW-1:0]     six_d;
    logic [CB+16:0]    sdn;
    logic [SW:0]       sr0;
    logic [15:0]       sq0;

    assign adv      = !v_reg[NS-1] || out_ready;
    assign in_ready = adv;

    always_comb begin
        six_d = HW'(in_item.delta) * HW'(6);
        term0 = in_item.add ? HW'(in_item.base) * HW'(in_item.delta) + HW'(in_item.num)
                            : HW'(in_item.base) * HW'(in_item.delta) - HW'(in_item.num);
        // saturation: delta*65535 = delta*65536 - delta; quotient below 65536
        sdn = {1'b0, in_item.delta, 16'd0} - (CB+17)'(in_item.delta);
        sr0 = '0;
        sq0 = '0;
        sr0 = (SW+1)'(sdn[CB+16:16]);
        sq0 = sdn[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    // hue numerator is term*65536; term can reach 6*delta (a full turn), which
    // is folded back to zero so the remainder starts below the divisor
    always_ff @(posedge aclk) begin
        if (adv) begin
            blk_reg[0] <= in_item.black;
            gry_reg[0] <= in_item.gray;
            mx_reg[0]  <= in_item.maxv;
            hd_reg[0]  <= six_d;
            hr_reg[0]  <= (term0 >= six_d) ? {1'b0, term0 - six_d} : {1'b0, term0};
            hq_reg[0]  <= '0;
            // saturation remainder holds high part of dividend; numerator < max*65536
            sr_reg[0]  <= sr0;
            sq_reg[0]  <= sq0;
            for (int i = 1; i < NS; i++) begin
                logic [HW+1:0] ht;
                logic [SW+1:0] st;
                ht = {hr_reg[i-1], 1'b0} - {2'b0, hd_reg[i-1]};
                st = {sr_reg[i-1], sq_reg[i-1][15]} - {2'b0, mx_reg[i-1]};
                blk_reg[i] <= blk_reg[i-1];
                gry_reg[i] <= gry_reg[i-1];
                mx_reg[i]  <= mx_reg[i-1];
                hd_reg[i]  <= hd_reg[i-1];
                if (!ht[HW+1]) begin
                    hr_reg[i] <= ht[HW:0];
                    hq_reg[i] <= {hq_reg[i-1][14:0], 1'b1};
                end else begin
                    hr_reg[i] <= {hr_reg[i-1][HW-1:0], 1'b0};
                    hq_reg[i] <= {hq_reg[i-1][14:0], 1'b0};
                end
                if (!st[SW+1]) begin
                    sr_reg[i] <= st[SW:0];
                    sq_reg[i] <= {sq_reg[i-1][14:0], 1'b1};
                end else begin
                    sr_reg[i] <= {sr_reg[i-1][SW-1:0], sq_reg[i-1][15]};
                    sq_reg[i] <= {sq_reg[i-1][14:0], 1'b0};
                end
            end
        end
    end

    assign out_valid  = v_reg[NS-1];
    assign value      = mx_reg[NS-1];
    assign saturation = blk_reg[NS-1] ? 16'd0 : sq_reg[NS-1];
    assign hue        = (blk_reg[NS-1] || gry_reg[NS-1]) ? 16'd0 : hq_reg[NS-1];

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && blk_reg[NS-1] |-> gry_reg[NS-1])
        else $error("black pixel not gray");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !blk_reg[NS-1] && gry_reg[NS-1] |-> saturation == 16'd0)
        else $error("gray pixel has saturation");

endmodule

[hdl/rgb_to_hsv_convert.sv]
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | red[7:0] green[15:8] blue[23:16]
// m_axis  | out | hue[15:0] saturation[31:16] value[39:32]
// one pixel per cycle sustained while m_axis is ready; a pixel passes the classify register, the fifo and
// 17 divider stages (a load stage, then one quotient bit per stage)
// aresetn synchronous active low clears all valid and pointer state
// a stall on m_axis freezes the whole divider pipe, then fills the 4-entry fifo, then stalls the front
module rgb_to_hsv_convert (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rgb2hsv_pkg::S_TDATA_BITS-1:0] s_axis_tdata,   // red, green, blue
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rgb2hsv_pkg::M_TDATA_BITS-1:0] m_axis_tdata    // hue, saturation, value
);

    localparam int CB = rgb2hsv_pkg::CHANNEL_BITS;
    localparam int MW = rgb2hsv_pkg::M_TDATA_BITS;

    logic              f_valid, f_ready, q_valid, q_ready;
    rgb2hsv_pkg::cls_t f_item, q_item;
    logic [15:0]       hue, saturation;
    rgb2hsv_pkg::chan_t value;

    rgb2hsv_front u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .red(s_axis_tdata[CB-1:0]), .green(s_axis_tdata[2*CB-1:CB]),
        .blue(s_axis_tdata[3*CB-1:2*CB]),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    rgb2hsv_fifo u_fifo (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    rgb2hsv_back u_back (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .hue, .saturation, .value
    );

    assign m_axis_tdata = MW'({value, saturation, hue});

endmodule
